### src/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants of the trouble code table
// Opcodes, status bit masks, controller commands and status.
// ----------------------------------------------------------------------------
package dtc_pkg;

	localparam logic [3:0] OP_PASSED     = 4'd0;
	localparam logic [3:0] OP_FAILED     = 4'd1;
	localparam logic [3:0] OP_PREPASSED  = 4'd2;
	localparam logic [3:0] OP_PREFAILED  = 4'd3;
	localparam logic [3:0] OP_GET_STATUS = 4'd4;
	localparam logic [3:0] OP_GET_DTC    = 4'd5;
	localparam logic [3:0] OP_CLEAR      = 4'd6;
	localparam logic [3:0] OP_COUNT      = 4'd7;
	localparam logic [3:0] OP_SET_FILTER = 4'd8;
	localparam logic [3:0] OP_NEXT       = 4'd9;

	localparam logic [23:0] DTC_BASE = 24'hC00000;
	localparam logic [23:0] DTC_ALL  = 24'hFFFFFF;
	localparam logic [7:0]  NOT_DONE_BITS = 8'h50;
	localparam logic [7:0]  FAIL_BITS     = 8'h2F;

	localparam logic CFG_FAIL = 1'b0;
	localparam logic CFG_PASS = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the input word, reset scan index
		logic scan;     // examine the entry at the scan index this cycle
		logic step;     // advance scan index by one
		logic apply;    // perform the write for the chosen entry
		logic finish;   // load the result register
	} dtc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last; // scan index is on the last entry
		logic stop;      // search may end early (next filtered hit)
	} dtc_stat_t;

endpackage

### src/dtc_ctrl.sv
// ----------------------------------------------------------------------------
// dtc_ctrl: sequencing controller
// Runs one scan over the table per word, then an update state and a result state.
// ----------------------------------------------------------------------------
module dtc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  dtc_pkg::dtc_stat_t  stat,
	output dtc_pkg::dtc_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_APPLY = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   free_out;

	// The result register is free when empty or being taken now.
	assign free_out  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.load   = in_valid;
			ST_SCAN: begin
				cmd.scan = 1'b1;
				cmd.step = !(stat.scan_last || stat.stop);
			end
			ST_APPLY: cmd.apply  = 1'b1;
			ST_DONE:  cmd.finish = free_out;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && free_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_SCAN;
				ST_SCAN:  if (stat.scan_last || stat.stop) state_q <= ST_APPLY;
				ST_APPLY: state_q <= ST_DONE;
				ST_DONE:  if (free_out) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/dtc_datapath.sv
// ----------------------------------------------------------------------------
// dtc_datapath: entry table, scan unit and result register
// Scans one entry per cycle and records the hits that each opcode needs.
// ----------------------------------------------------------------------------
module dtc_datapath #(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic        [7:0]  cfg_data,
	input  logic        [3:0]  opcode,
	input  logic        [15:0] event_id,
	input  logic        [23:0] dtc_number,
	input  logic        [7:0]  status_filter,
	input  dtc_pkg::dtc_cmd_t  cmd,
	output dtc_pkg::dtc_stat_t stat,
	output logic               ok,
	output logic        [7:0]  status_byte,
	output logic        [23:0] dtc_out,
	output logic        [8:0]  match_count
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [ENTRIES-1:0] valid_q;
	logic [15:0]        event_q  [ENTRIES];
	logic [7:0]         status_q [ENTRIES];
	logic signed [7:0]  deb_q    [ENTRIES];
	logic [7:0]         fmask_q;
	logic [8:0]         fpos_q;
	logic signed [7:0]  fail_q, pass_q;

	logic [3:0]  op_q;
	logic [15:0] ev_q;
	logic [23:0] dtc_q;
	logic [7:0]  msk_q;
	logic [IW-1:0] idx_q;
	logic        hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [8:0]  cnt_q;
	logic        r_ok_q;
	logic [7:0]  r_st_q;
	logic [23:0] r_dtc_q;
	logic [8:0]  r_cnt_q;

	logic        cur_valid, ev_match, nf_match, nf_range;
	logic [7:0]  cur_status;

	assign cur_valid  = valid_q[idx_q];
	assign cur_status = status_q[idx_q];
	assign ev_match   = cur_valid && (event_q[idx_q] == ev_q);
	assign nf_range   = ({{(9-IW){1'b0}}, idx_q} >= fpos_q);
	assign nf_match   = cur_valid && ((cur_status & fmask_q) != 8'd0) && nf_range;

	assign stat.scan_last = (idx_q == IW'(ENTRIES - 1));
	assign stat.stop      = (op_q == dtc_pkg::OP_NEXT) && nf_match;

	// Update of a report for the chosen entry.
	logic        rep_ok;
	logic [IW-1:0] rep_idx;
	logic [7:0]  s_old, s_new;
	logic signed [7:0] c_old, c_new;
	logic        is_new;

	always_comb begin
		rep_ok  = hit_q || free_q;
		rep_idx = hit_q ? hit_idx_q : free_idx_q;
		is_new  = !hit_q;
		s_old   = (is_new ? dtc_pkg::NOT_DONE_BITS : status_q[rep_idx])
			& ~dtc_pkg::NOT_DONE_BITS;
		c_old   = is_new ? 8'sd0 : deb_q[rep_idx];
		s_new   = s_old;
		c_new   = c_old;
		case (op_q)
			dtc_pkg::OP_FAILED: begin
				c_new = fail_q;
				s_new = s_old | dtc_pkg::FAIL_BITS;
			end
			dtc_pkg::OP_PASSED: begin
				c_new = pass_q;
				s_new = s_old & 8'hFE;
			end
			dtc_pkg::OP_PREFAILED: begin
				if (c_old < fail_q) c_new = c_old + 8'sd1;
				if (c_new >= fail_q) s_new = s_old | dtc_pkg::FAIL_BITS;
			end
			default: begin
				if (c_old > pass_q) c_new = c_old - 8'sd1;
				if (c_new <= pass_q) s_new = s_old & 8'hFE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fmask_q <= '0;
			fpos_q  <= '0;
			fail_q  <= 8'sd127;
			pass_q  <= -8'sd128;
		end else begin
			if (cfg_we) begin
				if (cfg_index == dtc_pkg::CFG_FAIL) fail_q <= cfg_data;
				else pass_q <= cfg_data;
			end
			if (cmd.apply) begin
				case (op_q)
					dtc_pkg::OP_PASSED, dtc_pkg::OP_FAILED,
					dtc_pkg::OP_PREPASSED, dtc_pkg::OP_PREFAILED: begin
						if (rep_ok) valid_q[rep_idx] <= 1'b1;
					end
					dtc_pkg::OP_SET_FILTER: begin
						fmask_q <= msk_q;
						fpos_q  <= '0;
					end
					dtc_pkg::OP_NEXT: if (hit_q) fpos_q <= 9'(hit_idx_q) + 9'd1;
					default: ;
				endcase
			end
			if (cmd.scan) begin
				if (op_q == dtc_pkg::OP_CLEAR && cur_valid &&
					(dtc_q == dtc_pkg::DTC_ALL ||
					 (dtc_pkg::DTC_BASE | {8'd0, event_q[idx_q]}) == dtc_q))
					valid_q[idx_q] <= 1'b0;
			end
		end
	end

	// Payload registers: table contents, captured word, scan results, result word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			ev_q   <= event_id;
			dtc_q  <= dtc_number;
			msk_q  <= status_filter;
			idx_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			cnt_q  <= '0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
		end else if (cmd.scan) begin
			if (cmd.step) idx_q <= idx_q + IW'(1);
			if (op_q == dtc_pkg::OP_NEXT) begin
				if (nf_match) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_q;
				end
			end else if (ev_match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if (!cur_valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (cur_valid && ((cur_status & msk_q) != 8'd0)) cnt_q <= cnt_q + 9'd1;
		end
		if (cmd.apply && rep_ok && op_q <= dtc_pkg::OP_PREFAILED) begin
			event_q[rep_idx]  <= ev_q;
			status_q[rep_idx] <= s_new;
			deb_q[rep_idx]    <= c_new;
		end
		if (cmd.finish) begin
			r_ok_q  <= 1'b0;
			r_st_q  <= '0;
			r_dtc_q <= '0;
			r_cnt_q <= '0;
			case (op_q)
				dtc_pkg::OP_PASSED, dtc_pkg::OP_FAILED,
				dtc_pkg::OP_PREPASSED, dtc_pkg::OP_PREFAILED: begin
					if (rep_ok) begin
						r_ok_q  <= 1'b1;
						r_st_q  <= status_q[rep_idx];
						r_dtc_q <= dtc_pkg::DTC_BASE | {8'd0, ev_q};
					end
				end
				dtc_pkg::OP_GET_STATUS, dtc_pkg::OP_GET_DTC, dtc_pkg::OP_NEXT: begin
					if (hit_q) begin
						r_ok_q  <= 1'b1;
						r_st_q  <= status_q[hit_idx_q];
						r_dtc_q <= dtc_pkg::DTC_BASE | {8'd0, event_q[hit_idx_q]};
					end
				end
				dtc_pkg::OP_CLEAR, dtc_pkg::OP_SET_FILTER: r_ok_q <= 1'b1;
				dtc_pkg::OP_COUNT: begin
					r_ok_q  <= 1'b1;
					r_cnt_q <= cnt_q;
				end
				default: ;
			endcase
		end
	end

	assign ok          = r_ok_q;
	assign status_byte = r_st_q;
	assign dtc_out     = r_dtc_q;
	assign match_count = r_cnt_q;

endmodule

### src/diagnostic_trouble_code_table.sv
// ----------------------------------------------------------------------------
// diagnostic_trouble_code_table: trouble code table with debounce counters
// Top level joining the sequencing controller and the table datapath.
// ----------------------------------------------------------------------------
// Usage:
// An input word (opcode, event_id, dtc_number, status_filter) is accepted
// when in_valid is high and in_stall is low. The block works on one word at
// a time and holds in_stall high until that word's result has been loaded.
// Each word walks the table one entry per cycle, then passes through an
// update state and a state that loads the result; next filtered stops the
// walk at its first hit. The input is free again once the result is
// loaded, so no new word is taken before the last one is finished.
// The result word (ok, status_byte, dtc_out, match_count) sits in an output
// register; it holds while out_stall is high, and a new word is taken while
// it waits. A finished word waits for the register to be freed.
// Reset clears all valid bits, the filter mask and cursor, and loads the
// default thresholds. The user must write thresholds through cfg_we,
// cfg_index and cfg_data only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module diagnostic_trouble_code_table #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [15:0] event_id,
	input  logic [23:0] dtc_number,
	input  logic [7:0]  status_filter,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [7:0]  status_byte,
	output logic [23:0] dtc_out,
	output logic [8:0]  match_count
);

	dtc_pkg::dtc_cmd_t  cmd;
	dtc_pkg::dtc_stat_t stat;

	dtc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	dtc_datapath #(.ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.opcode(opcode), .event_id(event_id), .dtc_number(dtc_number),
		.status_filter(status_filter),
		.cmd(cmd), .stat(stat),
		.ok(ok), .status_byte(status_byte), .dtc_out(dtc_out),
		.match_count(match_count)
	);

endmodule

### sim/tb_diagnostic_trouble_code_table.sv
// ----------------------------------------------------------------------------
// tb_diagnostic_trouble_code_table: self-checking bench for the code table
// Drives report, lookup, clear, count and filter words with random gaps on
// both handshakes, predicts every result word and compares field by field.
// ----------------------------------------------------------------------------
module tb_diagnostic_trouble_code_table;

	localparam int NUM_ENTRIES = 16;
	localparam int WATCHDOG_CYCLES = 20000;

	// One result word as the block returns it.
	typedef struct packed {
		logic        ok;
		logic [7:0]  status_byte;
		logic [23:0] dtc_out;
		logic [8:0]  match_count;
	} table_reply_t;

	// The scoreboard holds a private copy of the table and the thresholds,
	// works out the reply for each accepted word and queues it in order.
	class dtc_scoreboard;
		bit          valid_q[NUM_ENTRIES];
		logic [15:0] event_q[NUM_ENTRIES];
		logic [7:0]  status_q[NUM_ENTRIES];
		int          counter_q[NUM_ENTRIES];
		logic [7:0]  walk_mask;
		int          walk_pos;
		int          fail_level;
		int          pass_level;
		table_reply_t pending_replies[$];
		int          errors;
		int          checked;

		function void clear_state();
			foreach (valid_q[i]) valid_q[i] = 0;
			walk_mask = '0;
			walk_pos = 0;
			fail_level = 127;
			pass_level = -128;
			errors = 0;
			checked = 0;
		endfunction

		function void set_threshold(logic idx, logic [7:0] val);
			if (idx == dtc_pkg::CFG_FAIL) fail_level = $signed(val);
			else pass_level = $signed(val);
		endfunction

		function int lookup(logic [15:0] ev);
			for (int i = 0; i < NUM_ENTRIES; i++)
				if (valid_q[i] && event_q[i] == ev) return i;
			return -1;
		endfunction

		// Notes an accepted word and queues the reply it must produce.
		function void note_word(logic [3:0] op, logic [15:0] ev, logic [23:0] dtc,
				logic [7:0] msk);
			table_reply_t r;
			int e;
			logic [7:0] s;
			int c;
			r = '0;
			if (op <= dtc_pkg::OP_PREFAILED) begin
				e = lookup(ev);
				if (e < 0) begin
					for (int i = 0; i < NUM_ENTRIES; i++)
						if (!valid_q[i]) begin
							valid_q[i] = 1;
							event_q[i] = ev;
							status_q[i] = dtc_pkg::NOT_DONE_BITS;
							counter_q[i] = 0;
							e = i;
							break;
						end
				end
				if (e >= 0) begin
					s = status_q[e] & ~dtc_pkg::NOT_DONE_BITS;
					c = counter_q[e];
					case (op)
						dtc_pkg::OP_FAILED: begin
							c = fail_level;
							s |= dtc_pkg::FAIL_BITS;
						end
						dtc_pkg::OP_PASSED: begin
							c = pass_level;
							s &= 8'hFE;
						end
						dtc_pkg::OP_PREFAILED: begin
							if (c < fail_level) c++;
							if (c >= fail_level) s |= dtc_pkg::FAIL_BITS;
						end
						default: begin
							if (c > pass_level) c--;
							if (c <= pass_level) s &= 8'hFE;
						end
					endcase
					counter_q[e] = c;
					status_q[e] = s;
					r.ok = 1;
					r.status_byte = s;
					r.dtc_out = dtc_pkg::DTC_BASE | {8'd0, event_q[e]};
				end
			end else if (op == dtc_pkg::OP_GET_STATUS || op == dtc_pkg::OP_GET_DTC) begin
				e = lookup(ev);
				if (e >= 0) begin
					r.ok = 1;
					r.status_byte = status_q[e];
					r.dtc_out = dtc_pkg::DTC_BASE | {8'd0, event_q[e]};
				end
			end else if (op == dtc_pkg::OP_CLEAR) begin
				for (int i = 0; i < NUM_ENTRIES; i++)
					if (valid_q[i] && (dtc == dtc_pkg::DTC_ALL ||
						(dtc_pkg::DTC_BASE | {8'd0, event_q[i]}) == dtc))
						valid_q[i] = 0;
				r.ok = 1;
			end else if (op == dtc_pkg::OP_COUNT) begin
				for (int i = 0; i < NUM_ENTRIES; i++)
					if (valid_q[i] && (status_q[i] & msk) != 0) r.match_count++;
				r.ok = 1;
			end else if (op == dtc_pkg::OP_SET_FILTER) begin
				walk_mask = msk;
				walk_pos = 0;
				r.ok = 1;
			end else if (op == dtc_pkg::OP_NEXT) begin
				for (int p = walk_pos; p < NUM_ENTRIES; p++)
					if (valid_q[p] && (status_q[p] & walk_mask) != 0) begin
						r.ok = 1;
						r.status_byte = status_q[p];
						r.dtc_out = dtc_pkg::DTC_BASE | {8'd0, event_q[p]};
						walk_pos = p + 1;
						break;
					end
			end
			pending_replies.push_back(r);
		endfunction

		// Compares one result word with the oldest queued reply.
		function void check_reply(table_reply_t got);
			table_reply_t want;
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			checked++;
			if (got.ok !== want.ok) begin
				$display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
				errors++;
			end
			if (got.status_byte !== want.status_byte) begin
				$display("%0t: status_byte expected %h actual %h", $time,
					want.status_byte, got.status_byte);
				errors++;
			end
			if (got.dtc_out !== want.dtc_out) begin
				$display("%0t: dtc_out expected %h actual %h", $time,
					want.dtc_out, got.dtc_out);
				errors++;
			end
			if (got.match_count !== want.match_count) begin
				$display("%0t: match_count expected %0d actual %0d", $time,
					want.match_count, got.match_count);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  opcode;
	logic [15:0] event_id;
	logic [23:0] dtc_number;
	logic [7:0]  status_filter;
	logic        out_valid;
	logic        out_stall;
	logic        ok;
	logic [7:0]  status_byte;
	logic [23:0] dtc_out;
	logic [8:0]  match_count;

	dtc_scoreboard table_model;
	int  idle_cycles;
	int  words_sent;
	bit  hold_receiver;   // set by the stimulus to force one long hold-off

	diagnostic_trouble_code_table DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .event_id(event_id), .dtc_number(dtc_number),
		.status_filter(status_filter),
		.out_valid(out_valid), .out_stall(out_stall),
		.ok(ok), .status_byte(status_byte), .dtc_out(dtc_out),
		.match_count(match_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// Checking and the idle watchdog both work on the values seen at the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				table_model.note_word(opcode, event_id, dtc_number, status_filter);
			if (out_valid && !out_stall)
				table_model.check_reply({ok, status_byte, dtc_out, match_count});
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("watchdog expired after %0d idle cycles", idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Receiver: random stall stretches, plus one long forced hold-off.
	initial begin
		int gap;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_receiver) begin
				out_stall <= 1'b1;
				repeat (150) @(posedge clk);
				hold_receiver = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	// Offers one word and returns right after the edge that accepts it.
	task automatic send_word(logic [3:0] op, logic [15:0] ev, logic [23:0] dtc,
			logic [7:0] msk);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		event_id <= ev;
		dtc_number <= dtc;
		status_filter <= msk;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// Drops valid and waits until every queued reply has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (table_model.pending_replies.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_threshold(logic idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		table_model.set_threshold(idx, val);
	endtask

	// Event ids come from a small pool most of the time so that entries are
	// revisited and the table fills; sometimes any 16-bit value is used.
	function automatic logic [15:0] pick_event();
		if ($urandom_range(0, 7) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 23)) ^ 16'hA5A0;
	endfunction

	// Random phase: mostly report words on the pool, with lookups, counts,
	// filter walks, occasional clears and rare undefined opcodes mixed in.
	task automatic random_phase(int n);
		int k;
		logic [15:0] ev;
		logic [23:0] dtc;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			ev = pick_event();
			dtc = 24'($urandom);
			if (k < 55)
				send_word(4'($urandom_range(dtc_pkg::OP_PASSED, dtc_pkg::OP_PREFAILED)),
					ev, dtc, 8'($urandom));
			else if (k < 70)
				send_word(($urandom_range(0, 1) ? dtc_pkg::OP_GET_STATUS :
					dtc_pkg::OP_GET_DTC), ev, dtc, 8'($urandom));
			else if (k < 75)
				send_word(dtc_pkg::OP_COUNT, ev, dtc, 8'($urandom));
			else if (k < 80)
				send_word(dtc_pkg::OP_SET_FILTER, ev, dtc, 8'($urandom));
			else if (k < 92)
				send_word(dtc_pkg::OP_NEXT, ev, dtc, 8'($urandom));
			else if (k < 97)
				send_word(dtc_pkg::OP_CLEAR, ev,
					($urandom_range(0, 2) ? dtc_pkg::DTC_BASE | {8'd0, ev} : dtc),
					8'($urandom));
			else if (k < 98)
				send_word(dtc_pkg::OP_CLEAR, ev, dtc_pkg::DTC_ALL, 8'($urandom));
			else
				send_word(4'($urandom_range(10, 15)), ev, dtc, 8'($urandom));
		end
	endtask

	initial begin
		table_model = new();
		table_model.clear_state();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dtc_pkg::CFG_FAIL;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = dtc_pkg::OP_PASSED;
		event_id = '0;
		dtc_number = '0;
		status_filter = '0;
		idle_cycles = 0;
		words_sent = 0;
		hold_receiver = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset thresholds: lookup miss, every report,
		// debounce steps, lookup hits, count, filter walk, a bad opcode, clears.
		send_word(dtc_pkg::OP_GET_STATUS, 16'hFFFF, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_PREFAILED, 16'h0000, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_PREPASSED, 16'hFFFF, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_FAILED, 16'h1234, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_PASSED, 16'h1234, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_GET_STATUS, 16'h1234, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_GET_DTC, 16'h0000, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_COUNT, 16'h0, 24'h0, 8'hFF);
		send_word(dtc_pkg::OP_SET_FILTER, 16'h0, 24'h0, 8'h08);
		send_word(dtc_pkg::OP_NEXT, 16'h0, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_NEXT, 16'h0, 24'h0, 8'h00);
		send_word(4'd15, 16'h1234, 24'hFFFFFF, 8'hFF);
		send_word(dtc_pkg::OP_CLEAR, 16'h0, 24'hC01234, 8'h00);
		send_word(dtc_pkg::OP_CLEAR, 16'h0, 24'h123456, 8'h00);
		// Fill the table; the last event of the loop and one more event find it full.
		for (int i = 0; i < NUM_ENTRIES; i++)
			send_word(dtc_pkg::OP_FAILED, 16'(i * 4099), 24'h0, 8'h00);
		send_word(dtc_pkg::OP_PREFAILED, 16'hBEEF, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_COUNT, 16'h0, 24'h0, 8'h01);
		send_word(dtc_pkg::OP_CLEAR, 16'h0, dtc_pkg::DTC_ALL, 8'h00);
		drain();

		// Thresholds of +1 and -1: a single debounce step from zero reaches each of them.
		write_threshold(dtc_pkg::CFG_FAIL, 8'sd1);
		write_threshold(dtc_pkg::CFG_PASS, -8'sd1);
		send_word(dtc_pkg::OP_PREFAILED, 16'h0042, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_PREPASSED, 16'h0042, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_PREPASSED, 16'h0042, 24'h0, 8'h00);
		send_word(dtc_pkg::OP_PREPASSED, 16'h0042, 24'h0, 8'h00);
		random_phase(300);
		drain();

		write_threshold(dtc_pkg::CFG_FAIL, 8'h80);
		write_threshold(dtc_pkg::CFG_PASS, 8'h7F);
		random_phase(300);
		drain();

		// Long receiver hold-off while the sender keeps offering words.
		write_threshold(dtc_pkg::CFG_FAIL, 8'd3);
		write_threshold(dtc_pkg::CFG_PASS, -8'sd3);
		hold_receiver = 1;
		random_phase(320);
		drain();

		write_threshold(dtc_pkg::CFG_FAIL, 8'd127);
		write_threshold(dtc_pkg::CFG_PASS, -8'sd128);
		random_phase(300);
		drain();

		$display("sent %0d words over four threshold settings, %0d replies checked",
			words_sent, table_model.checked);
		if (table_model.errors == 0 && table_model.pending_replies.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
